// ===== hw/rtl/alawpkt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alawpkt_pkg
// Types and constants shared by the A-law audio packetizer.
// ----------------------------------------------------------------------------
package alawpkt_pkg;

    localparam int SampleWidth = 16;
    localparam int ByteWidth   = 8;
    localparam int TsWidth     = 32;
    localparam int CfgIdxWidth = 2;
    localparam int CfgDatWidth = 8;

    localparam logic [CfgIdxWidth-1:0] CFG_DECIMATION = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_PACKET_LEN = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_FRAME_MS   = 2'd2;

    localparam logic [1:0]           DECIM_RESET     = 2'd1;
    localparam logic [1:0]           DECIM_HALF      = 2'd2;
    localparam logic [ByteWidth-1:0] PACKET_LEN_RESET = 8'd160;
    localparam logic [ByteWidth-1:0] FRAME_MS_RESET   = 8'd20;

    localparam logic [ByteWidth-1:0] ALAW_XOR_MASK = 8'h55;

    typedef struct packed {
        logic [1:0]           decimation;
        logic [ByteWidth-1:0] packet_len;
        logic [ByteWidth-1:0] frame_ms;
    } cfg_t;

    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [TsWidth-1:0]   ts;
        logic [ByteWidth-1:0] count;
    } frame_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/alawpkt_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alawpkt_in_if
// Sample channel: command and signed PCM sample with valid/ready.
// ----------------------------------------------------------------------------
interface alawpkt_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic signed [15:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/alawpkt_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alawpkt_out_if
// Byte channel: A-law byte, packet end flag and packet timestamp.
// ----------------------------------------------------------------------------
interface alawpkt_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  alaw_byte;
    logic        last_in_packet;
    logic [31:0] packet_ts;

    modport source (output valid, output alaw_byte, output last_in_packet,
                    output packet_ts, input ready);
    modport sink   (input valid, input alaw_byte, input last_in_packet,
                    input packet_ts, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/alawpkt_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alawpkt_encoder
// G.711 A-law encode of one 16-bit PCM sample, combinational.
// ----------------------------------------------------------------------------
module alawpkt_encoder (
    input  wire logic [alawpkt_pkg::SampleWidth-1:0] sample,
    output logic      [alawpkt_pkg::ByteWidth-1:0]   alaw_byte
);
    import alawpkt_pkg::*;

    logic        sign;
    logic [14:0] mag;
    logic [2:0]  seg;
    logic [3:0]  mant;

    always_comb
    begin
        if (sample[15])
        begin
            sign = 1'b0;
            mag  = ~sample[14:0];
        end
        else
        begin
            sign = 1'b1;
            mag  = sample[14:0];
        end
    end

    always_comb
    begin
        if (mag[14])      seg = 3'd7;
        else if (mag[13]) seg = 3'd6;
        else if (mag[12]) seg = 3'd5;
        else if (mag[11]) seg = 3'd4;
        else if (mag[10]) seg = 3'd3;
        else if (mag[9])  seg = 3'd2;
        else if (mag[8])  seg = 3'd1;
        else              seg = 3'd0;
    end

    always_comb
    begin
        case (seg)
            3'd0:    mant = mag[7:4];
            3'd1:    mant = mag[7:4];
            3'd2:    mant = mag[8:5];
            3'd3:    mant = mag[9:6];
            3'd4:    mant = mag[10:7];
            3'd5:    mant = mag[11:8];
            3'd6:    mant = mag[12:9];
            default: mant = mag[13:10];
        endcase
    end

    assign alaw_byte = {sign, seg, mant} ^ ALAW_XOR_MASK;

endmodule

`default_nettype wire

// ===== hw/rtl/alawpkt_framer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alawpkt_framer
// Decimation phase, byte count and packet timestamp state.
// ----------------------------------------------------------------------------
module alawpkt_framer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic                       cmd,
    input  wire alawpkt_pkg::cfg_t          cfg,
    output alawpkt_pkg::frame_status_t      status
);
    import alawpkt_pkg::*;

    logic                 skip_reg;
    logic                 skip_next;
    logic [ByteWidth-1:0] count_reg;
    logic [ByteWidth-1:0] count_next;
    logic [TsWidth-1:0]   ts_reg;
    logic [TsWidth-1:0]   ts_next;

    logic                 half;
    logic [ByteWidth-1:0] len_eff;
    logic [ByteWidth:0]   count_inc;
    logic                 emit;
    logic                 last;

    assign half      = (cfg.decimation == DECIM_HALF);
    assign len_eff   = (cfg.packet_len == '0) ? ByteWidth'(1) : cfg.packet_len;
    assign count_inc = {1'b0, count_reg} + (ByteWidth+1)'(1);
    assign emit      = !cmd && !(half && skip_reg);
    assign last      = (count_inc >= {1'b0, len_eff});

    always_comb
    begin
        skip_next  = skip_reg;
        count_next = count_reg;
        ts_next    = ts_reg;
        if (step)
        begin
            if (cmd)
            begin
                skip_next  = 1'b0;
                count_next = '0;
                ts_next    = '0;
            end
            else if (!emit)
            begin
                skip_next = 1'b0;
            end
            else
            begin
                skip_next = half;
                if (last)
                begin
                    count_next = '0;
                    ts_next    = ts_reg + TsWidth'(cfg.frame_ms);
                end
                else
                begin
                    count_next = count_inc[ByteWidth-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg  <= 1'b0;
            count_reg <= '0;
            ts_reg    <= '0;
        end
        else
        begin
            skip_reg  <= skip_next;
            count_reg <= count_next;
            ts_reg    <= ts_next;
        end
    end

    assign status.emit  = emit;
    assign status.last  = last;
    assign status.ts    = ts_reg;
    assign status.count = count_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/alaw_audio_packetizer_core.sv =====
`default_nettype none
// An accepted sample beat passes the input register and then the output register
// before its byte appears on the output. Throughput: one beat per cycle while the
// byte channel is ready; input register feeds the encoder and framer, whose result lands in the output register.
// Restart and dropped samples leave the input stage without waiting for the output and produce no output.
// Reset: asynchronous, clears pipeline valids and stream state; registers
// return to decimation 1, packet length 160, frame 20 ms.
// ----------------------------------------------------------------------------
// alaw_audio_packetizer_core
// G.711 A-law encoder with decimation and fixed-length packet framing.
// ----------------------------------------------------------------------------
module alaw_audio_packetizer_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    alawpkt_in_if.sink                               sample_ch,
    alawpkt_out_if.source                            byte_ch,
    input  wire logic                                cfg_we,
    input  wire logic [alawpkt_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [alawpkt_pkg::CfgDatWidth-1:0] cfg_data
);
    import alawpkt_pkg::*;

    cfg_t cfg_reg;

    logic                   s1_valid_reg;
    logic                   s1_cmd_reg;
    logic [SampleWidth-1:0] s1_sample_reg;

    logic                 out_valid_reg;
    logic [ByteWidth-1:0] out_byte_reg;
    logic                 out_last_reg;
    logic [TsWidth-1:0]   out_ts_reg;

    frame_status_t        status;
    logic [ByteWidth-1:0] enc_byte;
    logic                 out_free;
    logic                 s1_fire;
    logic                 in_fire;
    logic                 load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decimation <= DECIM_RESET;
            cfg_reg.packet_len <= PACKET_LEN_RESET;
            cfg_reg.frame_ms   <= FRAME_MS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DECIMATION: cfg_reg.decimation <= cfg_data[1:0];
                CFG_PACKET_LEN: cfg_reg.packet_len <= cfg_data;
                CFG_FRAME_MS:   cfg_reg.frame_ms   <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign out_free        = !out_valid_reg || byte_ch.ready;
    assign s1_fire         = s1_valid_reg && (out_free || !status.emit);
    assign load_out        = s1_fire && status.emit;
    assign sample_ch.ready = !s1_valid_reg || s1_fire;
    assign in_fire         = sample_ch.valid && sample_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_ch.ready)
        begin
            s1_valid_reg <= sample_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg    <= sample_ch.cmd;
            s1_sample_reg <= sample_ch.sample;
        end
    end

    alawpkt_encoder u_encoder (
        .sample    (s1_sample_reg),
        .alaw_byte (enc_byte)
    );

    alawpkt_framer u_framer (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_fire),
        .cmd    (s1_cmd_reg),
        .cfg    (cfg_reg),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (byte_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_byte_reg <= enc_byte;
            out_last_reg <= status.last;
            out_ts_reg   <= status.ts;
        end
    end

    assign byte_ch.valid          = out_valid_reg;
    assign byte_ch.alaw_byte      = out_byte_reg;
    assign byte_ch.last_in_packet = out_last_reg;
    assign byte_ch.packet_ts      = out_ts_reg;

`ifndef ASSERT_OFF
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && (out_ts_reg == $past(status.ts)))
        else $error("loaded byte not presented with its packet timestamp");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_cmd_reg |=> (status.count == '0) && (status.ts == '0))
        else $error("restart did not clear count and timestamp");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && status.last |=> status.count == '0)
        else $error("byte count not cleared after packet end");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_alaw_audio_packetizer_core.sv =====
// ----------------------------------------------------------------------------
// tb_alaw_audio_packetizer_core
// Self-checking bench for the A-law packetizer: drives PCM samples and
// restarts, tracks decimation, packet framing and timestamps in a local
// model, and checks every output byte beat against it, partly under random stalls.
// ----------------------------------------------------------------------------
module tb_alaw_audio_packetizer_core;

    timeunit 1ns;
    timeprecision 1ps;

    import alawpkt_pkg::*;

    typedef enum logic
    {
        CMD_SAMPLE  = 1'b0,
        CMD_RESTART = 1'b1
    } stream_cmd_e;

    typedef struct packed {
        logic [ByteWidth-1:0] alaw_byte;
        logic                 last;
        logic [TsWidth-1:0]   ts;
    } byte_beat_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [CfgDatWidth-1:0] cfg_data;

    alawpkt_in_if  sample_ch ();
    alawpkt_out_if byte_ch ();

    alaw_audio_packetizer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch.sink),
        .byte_ch   (byte_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [1:0]           decim_reg;
    logic [ByteWidth-1:0] plen_reg;
    logic [ByteWidth-1:0] frame_reg;
    logic                 skip_next;
    logic [ByteWidth-1:0] bytes_in_packet;
    logic [TsWidth-1:0]   stream_ts;

    byte_beat_t pending_bytes[$];
    int         err_cnt = 0;
    int         src_idle_pct;
    int         snk_idle_pct;

    logic signed [SampleWidth-1:0] corner_pcm [16] = '{
        16'sd0, -16'sd1, 16'sd1, 16'sd32767, -16'sd32768, 16'sd255, 16'sd256,
        -16'sd256, -16'sd257, 16'sd4095, 16'sd4096, 16'sd8191, 16'sd8192,
        16'sd16383, 16'sd16384, -16'sd16385
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [ByteWidth-1:0] encode_alaw(logic signed [SampleWidth-1:0] pcm);
        logic        pos;
        logic [14:0] mag;
        logic [2:0]  seg;
        logic [3:0]  mant;
        pos = !pcm[15];
        mag = pos ? pcm[14:0] : ~pcm[14:0];
        seg = 3'd0;
        for (int k = 1; k < 8; k++)
            if (mag >= (15'd128 << k))
                seg = 3'(k);
        mant = (seg == 3'd0) ? mag[7:4] : 4'(mag >> (int'(seg) + 3));
        return {pos, seg, mant} ^ ALAW_XOR_MASK;
    endfunction

    function automatic void advance_stream(stream_cmd_e op, logic signed [SampleWidth-1:0] pcm);
        byte_beat_t           beat;
        logic [ByteWidth-1:0] eff_len;
        if (op == CMD_RESTART)
        begin
            skip_next       = 1'b0;
            bytes_in_packet = '0;
            stream_ts       = '0;
            return;
        end
        if (decim_reg == DECIM_HALF)
        begin
            if (skip_next)
            begin
                skip_next = 1'b0;
                return;
            end
            skip_next = 1'b1;
        end
        else
            skip_next = 1'b0;
        eff_len        = (plen_reg == '0) ? 8'd1 : plen_reg;
        beat.alaw_byte = encode_alaw(pcm);
        beat.last      = ({1'b0, bytes_in_packet} + 9'd1) >= {1'b0, eff_len};
        beat.ts        = stream_ts;
        pending_bytes.push_back(beat);
        if (beat.last)
        begin
            bytes_in_packet = '0;
            stream_ts       = stream_ts + TsWidth'(frame_reg);
        end
        else
            bytes_in_packet = bytes_in_packet + 8'd1;
    endfunction

    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDatWidth-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_DECIMATION: decim_reg = val[1:0];
            CFG_PACKET_LEN: plen_reg  = val;
            CFG_FRAME_MS:   frame_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [1:0] decim, logic [7:0] plen, logic [7:0] frame);
        write_reg(CFG_DECIMATION, {6'($urandom), decim});
        write_reg(CFG_PACKET_LEN, plen);
        write_reg(CFG_FRAME_MS, frame);
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(stream_cmd_e op, logic signed [SampleWidth-1:0] pcm);
        sample_ch.valid  <= 1'b1;
        sample_ch.cmd    <= op;
        sample_ch.sample <= pcm;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        advance_stream(op, pcm);
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < src_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    task automatic drain_bytes();
        sample_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_encode_corners();
        foreach (corner_pcm[i])
        begin
            send_sample(CMD_SAMPLE, corner_pcm[i]);
            sender_gap();
        end
        drain_bytes();
    endtask

    task automatic test_framing_cases();
        set_config(DECIM_HALF, 8'd3, 8'd255);
        repeat (7) send_sample(CMD_SAMPLE, 16'($urandom));
        drain_bytes();
        // leave half-rate with a drop pending
        set_config(2'd1, 8'd3, 8'd255);
        repeat (2) send_sample(CMD_SAMPLE, 16'($urandom));
        drain_bytes();
        set_config(2'd3, 8'd0, 8'd9);
        repeat (2) send_sample(CMD_SAMPLE, 16'($urandom));
        drain_bytes();
        set_config(2'd0, 8'd200, 8'd0);
        repeat (4) send_sample(CMD_SAMPLE, 16'($urandom));
        drain_bytes();
        // shrink the packet below the bytes already sent
        set_config(2'd0, 8'd2, 8'd0);
        send_sample(CMD_SAMPLE, 16'($urandom));
        send_sample(CMD_RESTART, 16'($urandom));
        send_sample(CMD_SAMPLE, 16'($urandom));
        drain_bytes();
    endtask

    task automatic test_random_stream();
        logic signed [SampleWidth-1:0] pcm;
        stream_cmd_e                   op;
        int                            bound;
        for (int seg = 0; seg < 8; seg++)
        begin
            drain_bytes();
            case (seg)
                0: set_config(2'd1, 8'd1, 8'd255);
                1: set_config(DECIM_HALF, 8'd255, 8'd0);
                2: set_config(2'd0, 8'd2, 8'd17);
                3: set_config(2'd3, 8'd7, 8'd1);
                4: set_config(DECIM_HALF, 8'd1, 8'd255);
                5: set_config(2'd1, 8'd255, 8'd20);
                default: set_config(2'($urandom), 8'($urandom_range(1, 12)), 8'($urandom));
            endcase
            case (seg % 4)
                0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
                1: begin src_idle_pct = 51; snk_idle_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_idle_pct = 51; end
                default: begin src_idle_pct = 14; snk_idle_pct = 14; end
            endcase
            for (int i = 0; i < 212; i++)
            begin
                op = ($urandom_range(99) < 3) ? CMD_RESTART : CMD_SAMPLE;
                case ($urandom_range(3))
                    0: pcm = 16'($urandom);
                    1:
                    begin
                        bound = (128 << $urandom_range(1, 7)) + $urandom_range(0, 2) - 1;
                        pcm = $urandom_range(1) ? 16'(bound) : 16'(-bound - 1);
                    end
                    2: pcm = 16'($urandom_range(600) - 300);
                    default: pcm = corner_pcm[$urandom_range(15)];
                endcase
                send_sample(op, pcm);
                if ($urandom_range(199) == 0)
                    drain_bytes();
                else
                    sender_gap();
            end
        end
        drain_bytes();
    endtask

    always @(posedge clk)
        byte_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        byte_beat_t want;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected byte beat: alaw_byte %h", byte_ch.alaw_byte);
                err_cnt++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (byte_ch.alaw_byte !== want.alaw_byte)
                begin
                    $error("alaw_byte: expected %h, got %h", want.alaw_byte, byte_ch.alaw_byte);
                    err_cnt++;
                end
                if (byte_ch.last_in_packet !== want.last)
                begin
                    $error("last_in_packet: expected %b, got %b", want.last,
                           byte_ch.last_in_packet);
                    err_cnt++;
                end
                if (byte_ch.packet_ts !== want.ts)
                begin
                    $error("packet_ts: expected %0d, got %0d", want.ts, byte_ch.packet_ts);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.cmd    = CMD_SAMPLE;
        sample_ch.sample = '0;
        src_idle_pct     = 0;
        snk_idle_pct     = 0;
        decim_reg        = DECIM_RESET;
        plen_reg         = PACKET_LEN_RESET;
        frame_reg        = FRAME_MS_RESET;
        skip_next        = 1'b0;
        bytes_in_packet  = '0;
        stream_ts        = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_corners();
        test_framing_cases();
        test_random_stream();

        if (err_cnt == 0 && pending_bytes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
